### sv/framebuffer_pixel_writer_assert.svh
// Assertion macros used by the port checker of the pixel writer.
`ifndef FRAMEBUFFER_PIXEL_WRITER_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_WRITER_ASSERT_SVH

// Property that must hold in the same cycle as its trigger.
`define FPW_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Property that must hold in the cycle after its trigger.
`define FPW_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/fpw_pkg.sv
package fpw_pkg;

	localparam int FB_BYTES   = 32768;
	localparam int COORD_BITS = 10;

	localparam int FB_AW      = $clog2(FB_BYTES);
	localparam int BANK_AW    = FB_AW - 1;
	localparam int BANK_DEPTH = FB_BYTES / 2;

	localparam int DIM_W     = 11;
	localparam int PITCH_W   = 12;
	localparam int COLOR_W   = 16;
	localparam int RADDR_W   = 15;
	localparam int COL_W     = DIM_W + 1;
	localparam int PROD_W    = DIM_W + PITCH_W;
	localparam int ADDR_W    = PROD_W + 1;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;

	localparam logic [7:0] MASK_1BPP = 8'h80;
	localparam logic [7:0] MASK_2BPP = 8'hC0;
	localparam logic [7:0] MASK_4BPP = 8'hF0;

	localparam logic [DIM_W-1:0]   RST_MEM_WIDTH  = DIM_W'(128);
	localparam logic [DIM_W-1:0]   RST_MEM_HEIGHT = DIM_W'(128);
	localparam logic [PITCH_W-1:0] RST_ROW_PITCH  = PITCH_W'(64);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MEM_WIDTH,
		CFG_MEM_HEIGHT,
		CFG_ROW_PITCH,
		CFG_ROTATION,
		CFG_MIRROR,
		CFG_DEPTH
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ROT_0,
		ROT_90,
		ROT_180,
		ROT_270
	} rot_t;

	typedef enum logic [1:0] {
		DEPTH_1BPP,
		DEPTH_2BPP,
		DEPTH_4BPP,
		DEPTH_16BPP
	} depth_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_MIRROR,
		ST_MUL,
		ST_ADDR,
		ST_FINISH
	} state_t;

	// Access to the two byte banks: bank 0 holds even bytes, bank 1 odd bytes.
	typedef struct packed {
		logic               rd;
		logic               we0;
		logic               we1;
		logic [BANK_AW-1:0] idx0;
		logic [BANK_AW-1:0] idx1;
		logic [7:0]         wd0;
		logic [7:0]         wd1;
	} mem_req_t;

endpackage

### sv/fpw_store.sv
module fpw_store
	import fpw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output logic     ready,
	output logic [7:0] rdata0,
	output logic [7:0] rdata1
);

	logic [7:0]         bank0_q [BANK_DEPTH];
	logic [7:0]         bank1_q [BANK_DEPTH];
	logic [7:0]         rdata0_q;
	logic [7:0]         rdata1_q;
	logic               clr_busy_q;
	logic [BANK_AW-1:0] clr_idx_q;

	logic               we0;
	logic               we1;
	logic [BANK_AW-1:0] widx0;
	logic [BANK_AW-1:0] widx1;
	logic [7:0]         wdat0;
	logic [7:0]         wdat1;

	// Both banks are swept to zero after reset, one row per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == BANK_AW'(BANK_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we0   = clr_busy_q | req.we0;
		we1   = clr_busy_q | req.we1;
		widx0 = clr_busy_q ? clr_idx_q : req.idx0;
		widx1 = clr_busy_q ? clr_idx_q : req.idx1;
		wdat0 = clr_busy_q ? 8'h00 : req.wd0;
		wdat1 = clr_busy_q ? 8'h00 : req.wd1;
	end

	always_ff @(posedge clk) begin
		if (we0) begin
			bank0_q[widx0] <= wdat0;
		end
		if (we1) begin
			bank1_q[widx1] <= wdat1;
		end
		if (req.rd) begin
			rdata0_q <= bank0_q[req.idx0];
			rdata1_q <= bank1_q[req.idx1];
		end
	end

	assign ready  = !clr_busy_q;
	assign rdata0 = rdata0_q;
	assign rdata1 = rdata1_q;

endmodule

### sv/framebuffer_pixel_writer.sv
// Packed framebuffer pixel writer. Each transfer on the input channel is either a pixel
// write (req_type 0) or a byte read (req_type 1), and each gives exactly one transfer on
// the output channel. A write checks the logical position against the rotated view,
// rotates and mirrors it, and turns it into a byte address using the configured row pitch
// and pixel depth; it then merges the colour into the stored byte at 1, 2 or 4 bits per
// pixel or stores two bytes, high byte first, at 16 bits per pixel. A zero colour at 1 bit
// per pixel clears the bit and any other colour sets it. Writes outside the view or past
// the end of the buffer change nothing and report status 1; a read past the end reports
// status 1 with a zero byte. Items are handled one at a time: a pixel write passes through
// the map, mirror, multiply and address states, then merges with the byte read back and
// loads its result, and a byte read loads its result from the registered read data of the
// store. The input side opens again in the cycle after the result is loaded. A result may
// wait in the output register while the next input transfer is already taken. After reset
// the store is cleared by a sweep over every index of both banks, during which in_stall
// stays high. The user must write registers through cfg_we, cfg_index and cfg_data only
// while no item is in flight; the block itself does not enforce this.
module framebuffer_pixel_writer
	import fpw_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  req_type,
	input  logic [COORD_BITS-1:0] pos_x,
	input  logic [COORD_BITS-1:0] pos_y,
	input  logic [COLOR_W-1:0]    pixel_color,
	input  logic [RADDR_W-1:0]    read_addr,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  status,
	output logic [7:0]            read_byte
);

	// Configuration registers.
	logic [DIM_W-1:0]   mem_width_q;
	logic [DIM_W-1:0]   mem_height_q;
	logic [PITCH_W-1:0] row_pitch_q;
	rot_t               rotation_q;
	logic [1:0]         mirror_q;
	depth_t             depth_q;

	// Control and the item in flight.
	state_t state_q;
	state_t state_d;

	logic                  req_q;
	logic [COORD_BITS-1:0] lx_q;
	logic [COORD_BITS-1:0] ly_q;
	logic [COLOR_W-1:0]    color_q;
	logic                  drop_q;
	logic [DIM_W-1:0]      px_q;
	logic [DIM_W-1:0]      py_q;
	logic [PROD_W-1:0]     prod_q;
	logic [COL_W-1:0]      col_q;
	logic [FB_AW-1:0]      addr_q;

	logic       out_valid_q;
	logic       status_q;
	logic [7:0] read_byte_q;

	// Store interface.
	mem_req_t   mem_req;
	logic       store_ready;
	logic [7:0] rdata0;
	logic [7:0] rdata1;

	logic in_accept;
	logic out_free;
	logic out_load;

	// Mapping and address arithmetic.
	logic [DIM_W-1:0]   view_w;
	logic [DIM_W-1:0]   view_h;
	logic               view_drop;
	logic [DIM_W-1:0]   lx_d;
	logic [DIM_W-1:0]   ly_d;
	logic [DIM_W-1:0]   px_map;
	logic [DIM_W-1:0]   py_map;
	logic [DIM_W-1:0]   px_mir;
	logic [DIM_W-1:0]   py_mir;
	logic [PROD_W-1:0]  prod_d;
	logic [COL_W-1:0]   col_d;
	logic [ADDR_W-1:0]  addr_full;
	logic               addr_ovf;
	logic [ADDR_W-1:0]  rd_addr_full;
	logic               rd_ovf;
	logic [BANK_AW-1:0] hi_idx;
	logic [7:0]         old_byte;
	logic [7:0]         new_byte;
	logic [2:0]         shift;
	logic [7:0]         merge_mask;
	logic [7:0]         merge_bits;

	fpw_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.ready  (store_ready),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	assign in_stall  = !((state_q == ST_IDLE) && store_ready);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = (state_q == ST_FINISH) && out_free;

	// Configuration writes. Indexes beyond the register list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_width_q  <= RST_MEM_WIDTH;
			mem_height_q <= RST_MEM_HEIGHT;
			row_pitch_q  <= RST_ROW_PITCH;
			rotation_q   <= ROT_0;
			mirror_q     <= 2'b00;
			depth_q      <= DEPTH_4BPP;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MEM_WIDTH:  mem_width_q  <= cfg_data[DIM_W-1:0];
				CFG_MEM_HEIGHT: mem_height_q <= cfg_data[DIM_W-1:0];
				CFG_ROW_PITCH:  row_pitch_q  <= cfg_data[PITCH_W-1:0];
				CFG_ROTATION:   rotation_q   <= rot_t'(cfg_data[1:0]);
				CFG_MIRROR:     mirror_q     <= cfg_data[1:0];
				CFG_DEPTH:      depth_q      <= depth_t'(cfg_data[1:0]);
				default: ;
			endcase
		end
	end

	// The view is transposed for quarter turns. Once a position passes the view check,
	// every subtraction below stays in range, so no second bounds check is needed.
	always_comb begin
		view_w    = rotation_q[0] ? mem_height_q : mem_width_q;
		view_h    = rotation_q[0] ? mem_width_q : mem_height_q;
		view_drop = (32'(lx_q) >= 32'(view_w)) || (32'(ly_q) >= 32'(view_h));
		lx_d      = DIM_W'(lx_q);
		ly_d      = DIM_W'(ly_q);
		case (rotation_q)
			ROT_90: begin
				px_map = mem_width_q - ly_d - 1'b1;
				py_map = lx_d;
			end
			ROT_180: begin
				px_map = mem_width_q - lx_d - 1'b1;
				py_map = mem_height_q - ly_d - 1'b1;
			end
			ROT_270: begin
				px_map = ly_d;
				py_map = mem_height_q - lx_d - 1'b1;
			end
			default: begin
				px_map = lx_d;
				py_map = ly_d;
			end
		endcase
	end

	always_comb begin
		px_mir = mirror_q[0] ? (mem_width_q - px_q - 1'b1) : px_q;
		py_mir = mirror_q[1] ? (mem_height_q - py_q - 1'b1) : py_q;
	end

	// Row offset and column byte offset for the configured depth.
	always_comb begin
		prod_d = PROD_W'(py_q) * PROD_W'(row_pitch_q);
		case (depth_q)
			DEPTH_1BPP:  col_d = COL_W'(px_q >> 3);
			DEPTH_2BPP:  col_d = COL_W'(px_q >> 2);
			DEPTH_4BPP:  col_d = COL_W'(px_q >> 1);
			default:     col_d = {px_q, 1'b0};
		endcase
	end

	// A 16-bit pixel also needs the byte after the addressed one to fit.
	always_comb begin
		addr_full    = ADDR_W'(prod_q) + ADDR_W'(col_q);
		addr_ovf     = (depth_q == DEPTH_16BPP) ? (addr_full >= ADDR_W'(FB_BYTES - 1))
		                                        : (addr_full >= ADDR_W'(FB_BYTES));
		rd_addr_full = ADDR_W'(read_addr);
		rd_ovf       = rd_addr_full >= ADDR_W'(FB_BYTES);
	end

	// Merge the colour into the byte read back from the store.
	always_comb begin
		hi_idx   = addr_q[FB_AW-1:1];
		old_byte = addr_q[0] ? rdata1 : rdata0;
		case (depth_q)
			DEPTH_1BPP: begin
				shift      = px_q[2:0];
				merge_mask = MASK_1BPP >> shift;
				merge_bits = (color_q != '0) ? merge_mask : 8'h00;
			end
			DEPTH_2BPP: begin
				shift      = {px_q[1:0], 1'b0};
				merge_mask = MASK_2BPP >> shift;
				merge_bits = {color_q[1:0], 6'b0} >> shift;
			end
			default: begin
				shift      = {px_q[0], 2'b00};
				merge_mask = MASK_4BPP >> shift;
				merge_bits = {color_q[3:0], 4'b0} >> shift;
			end
		endcase
		new_byte = (old_byte & ~merge_mask) | merge_bits;
	end

	// Sequencer: next state and store accesses.
	always_comb begin
		state_d = state_q;
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					if (req_type) begin
						mem_req.rd   = 1'b1;
						mem_req.idx0 = rd_addr_full[FB_AW-1:1];
						mem_req.idx1 = rd_addr_full[FB_AW-1:1];
						state_d      = ST_FINISH;
					end else begin
						state_d = ST_MAP;
					end
				end
			end
			ST_MAP:    state_d = ST_MIRROR;
			ST_MIRROR: state_d = ST_MUL;
			ST_MUL:    state_d = ST_ADDR;
			ST_ADDR: begin
				mem_req.rd   = !drop_q && !addr_ovf && (depth_q != DEPTH_16BPP);
				mem_req.idx0 = addr_full[FB_AW-1:1];
				mem_req.idx1 = addr_full[FB_AW-1:1];
				state_d      = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
					if (!req_q && !drop_q) begin
						if (depth_q == DEPTH_16BPP) begin
							// High byte goes to the addressed byte, low byte to the next.
							mem_req.we0 = 1'b1;
							mem_req.we1 = 1'b1;
							if (!addr_q[0]) begin
								mem_req.idx0 = hi_idx;
								mem_req.idx1 = hi_idx;
								mem_req.wd0  = color_q[15:8];
								mem_req.wd1  = color_q[7:0];
							end else begin
								mem_req.idx1 = hi_idx;
								mem_req.idx0 = hi_idx + 1'b1;
								mem_req.wd1  = color_q[15:8];
								mem_req.wd0  = color_q[7:0];
							end
						end else begin
							mem_req.we0  = !addr_q[0];
							mem_req.we1  = addr_q[0];
							mem_req.idx0 = hi_idx;
							mem_req.idx1 = hi_idx;
							mem_req.wd0  = new_byte;
							mem_req.wd1  = new_byte;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_load || (out_valid_q && out_stall);
		end
	end

	// Datapath registers of the item in flight and the result register.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					req_q   <= req_type;
					lx_q    <= pos_x;
					ly_q    <= pos_y;
					color_q <= pixel_color;
					drop_q  <= req_type && rd_ovf;
					addr_q  <= rd_addr_full[FB_AW-1:0];
				end
			end
			ST_MAP: begin
				drop_q <= view_drop;
				px_q   <= px_map;
				py_q   <= py_map;
			end
			ST_MIRROR: begin
				px_q <= px_mir;
				py_q <= py_mir;
			end
			ST_MUL: begin
				prod_q <= prod_d;
				col_q  <= col_d;
			end
			ST_ADDR: begin
				drop_q <= drop_q || addr_ovf;
				addr_q <= addr_full[FB_AW-1:0];
			end
			default: ;
		endcase
		if (out_load) begin
			status_q    <= drop_q;
			read_byte_q <= (req_q && !drop_q) ? old_byte : 8'h00;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign read_byte = read_byte_q;

endmodule

### sv/fpw_port_checker.sv
`include "framebuffer_pixel_writer_assert.svh"

module fpw_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       status,
	input logic [7:0] read_byte
);

	// A stalled result holds.
	`FPW_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(read_byte), "stalled result changed")

	// Dropped requests never return data.
	`FPW_ASSERT_NOW(a_drop_zero, out_valid && status, read_byte == 8'h00, "dropped request returned data")

	// One item at a time: an accepted transfer makes the input side busy.
	`FPW_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall, "second item taken while busy")

	// A transfer on the output side follows an input transfer, so a fresh result that appears
	// from an open input side must trace back to a valid request.
	`FPW_ASSERT_NOW(a_no_spurious, $rose(out_valid) && !$past(in_stall), $past(in_valid), "result without a request")

endmodule

bind framebuffer_pixel_writer fpw_port_checker u_fpw_port_checker (.*);

### sim/tb_framebuffer_pixel_writer.sv
`default_nettype none

module tb_framebuffer_pixel_writer;
	timeunit 1ns;
	timeprecision 1ps;

	import fpw_pkg::*;

	// Request kinds on the req_type field.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	// Bit positions inside the mirror mode register.
	localparam int MIRROR_HORIZ = 0;
	localparam int MIRROR_VERT  = 1;

	// Percentage of cycles in which each side holds off.
	localparam int IDLE_PCT = 22;

	// Cycles without any transfer before the run is declared hung. The clearing
	// sweep after reset alone keeps the input stalled while it covers every bank index.
	localparam int QUIET_LIMIT = 60000;

	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 88;

	typedef struct {
		logic                  req_type;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic [COLOR_W-1:0]    pixel_color;
		logic [RADDR_W-1:0]    read_addr;
	} fb_req_t;

	typedef struct packed {
		logic       status;
		logic [7:0] read_byte;
	} fb_reply_t;

	// Clock, reset and every input of the block start from known values.
	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_we      = 1'b0;
	cfg_reg_t              cfg_index   = CFG_MEM_WIDTH;
	logic [CFG_W-1:0]      cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  req_type    = REQ_WRITE;
	logic [COORD_BITS-1:0] pos_x       = '0;
	logic [COORD_BITS-1:0] pos_y       = '0;
	logic [COLOR_W-1:0]    pixel_color = '0;
	logic [RADDR_W-1:0]    read_addr   = '0;
	logic                  out_stall   = 1'b0;
	logic                  in_stall;
	logic                  out_valid;
	logic                  status;
	logic [7:0]            read_byte;

	// Shadow copy of the register file, kept in step with every write we issue.
	logic [DIM_W-1:0]   view_width  = RST_MEM_WIDTH;
	logic [DIM_W-1:0]   view_height = RST_MEM_HEIGHT;
	logic [PITCH_W-1:0] view_pitch  = RST_ROW_PITCH;
	rot_t               view_rot    = ROT_0;
	logic [1:0]         view_mirror = '0;
	depth_t             view_depth  = DEPTH_4BPP;

	// Shadow copy of the framebuffer contents.
	logic [7:0] shadow_fb [FB_BYTES];

	fb_req_t     request_backlog[$];
	fb_reply_t   awaited_replies[$];
	int unsigned painted_addrs[$];

	// When set, neither side holds off: this gives a stretch at full rate.
	logic calm = 1'b0;

	int fail_count  = 0;
	int n_writes    = 0;
	int n_reads     = 0;
	int n_dropped   = 0;
	int n_replies   = 0;
	int n_settings  = 0;
	int quiet_count = 0;

	framebuffer_pixel_writer u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pixel_color (pixel_color),
		.read_addr   (read_addr),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.read_byte   (read_byte)
	);

	always #1 clk = ~clk;

	// Remembers a byte that a write has changed, so that later reads can be
	// aimed at data that is actually there. Only the most recent ones are kept.
	function automatic void note_painted(int unsigned addr);
		painted_addrs.push_back(addr);
		if (painted_addrs.size() > 128) begin
			void'(painted_addrs.pop_front());
		end
	endfunction

	// Works out the reply to one request and applies its effect to the shadow
	// framebuffer. A write is bounds-checked against the logical view, whose
	// sides swap under 90 and 270 degree rotation, then rotated, mirrored and
	// turned into a byte address from the row pitch and the pixel depth.
	function automatic fb_reply_t paint_or_fetch(fb_req_t rq);
		fb_reply_t   rep;
		int unsigned lx, ly, vw, vh, mw, mh, px, py, addr, sh, ins;
		logic [7:0]  bits;
		rep.status    = 1'b0;
		rep.read_byte = '0;
		if (rq.req_type == REQ_READ) begin
			n_reads++;
			if (rq.read_addr >= FB_BYTES) begin
				rep.status = 1'b1;
			end else begin
				rep.read_byte = shadow_fb[rq.read_addr];
			end
			return rep;
		end
		n_writes++;
		lx = rq.pos_x;
		ly = rq.pos_y;
		mw = view_width;
		mh = view_height;
		vw = (view_rot == ROT_90 || view_rot == ROT_270) ? mh : mw;
		vh = (view_rot == ROT_90 || view_rot == ROT_270) ? mw : mh;
		if (lx >= vw || ly >= vh) begin
			rep.status = 1'b1;
			n_dropped++;
			return rep;
		end
		case (view_rot)
			ROT_90: begin
				px = mw - ly - 1;
				py = lx;
			end
			ROT_180: begin
				px = mw - lx - 1;
				py = mh - ly - 1;
			end
			ROT_270: begin
				px = ly;
				py = mh - lx - 1;
			end
			default: begin
				px = lx;
				py = ly;
			end
		endcase
		if (view_mirror[MIRROR_HORIZ]) begin
			px = mw - px - 1;
		end
		if (view_mirror[MIRROR_VERT]) begin
			py = mh - py - 1;
		end
		if (px >= mw || py >= mh) begin
			rep.status = 1'b1;
			n_dropped++;
			return rep;
		end
		case (view_depth)
			DEPTH_1BPP: begin
				addr = (px >> 3) + py * view_pitch;
				bits = MASK_1BPP >> (px & 7);
			end
			DEPTH_2BPP: begin
				addr = (px >> 2) + py * view_pitch;
				sh   = (px & 3) * 2;
				bits = MASK_2BPP >> sh;
				ins  = ((int'(rq.pixel_color) & 3) << 6) >> sh;
			end
			DEPTH_4BPP: begin
				addr = (px >> 1) + py * view_pitch;
				sh   = (px & 1) * 4;
				bits = MASK_4BPP >> sh;
				ins  = ((int'(rq.pixel_color) & 15) << 4) >> sh;
			end
			default: begin
				addr = px * 2 + py * view_pitch;
			end
		endcase
		// At 16 bits per pixel both bytes must fit; otherwise one byte must.
		if ((view_depth == DEPTH_16BPP && addr + 1 >= FB_BYTES) || addr >= FB_BYTES) begin
			rep.status = 1'b1;
			n_dropped++;
			return rep;
		end
		case (view_depth)
			DEPTH_1BPP: begin
				if (rq.pixel_color == '0) begin
					shadow_fb[addr] = shadow_fb[addr] & ~bits;
				end else begin
					shadow_fb[addr] = shadow_fb[addr] | bits;
				end
			end
			DEPTH_16BPP: begin
				shadow_fb[addr]     = rq.pixel_color[15:8];
				shadow_fb[addr + 1] = rq.pixel_color[7:0];
				note_painted(addr + 1);
			end
			default: begin
				shadow_fb[addr] = (shadow_fb[addr] & ~bits) | 8'(ins);
			end
		endcase
		note_painted(addr);
		return rep;
	endfunction

	// Unused fields of each request carry random bits, so every input bit
	// toggles regardless of the request mix.
	function automatic void push_write(int unsigned x, int unsigned y, int unsigned color);
		fb_req_t rq;
		rq.req_type    = REQ_WRITE;
		rq.pos_x       = COORD_BITS'(x);
		rq.pos_y       = COORD_BITS'(y);
		rq.pixel_color = COLOR_W'(color);
		rq.read_addr   = RADDR_W'($urandom);
		request_backlog.push_back(rq);
	endfunction

	function automatic void push_read(int unsigned addr);
		fb_req_t rq;
		rq.req_type    = REQ_READ;
		rq.pos_x       = COORD_BITS'($urandom);
		rq.pos_y       = COORD_BITS'($urandom);
		rq.pixel_color = COLOR_W'($urandom);
		rq.read_addr   = RADDR_W'(addr);
		request_backlog.push_back(rq);
	endfunction

	// Mostly small image sides, so that writes land inside the buffer and
	// collide often, with the occasional very large one.
	function automatic int unsigned random_dim();
		case ($urandom_range(9))
			0:       return $urandom_range(4, 1);
			6:       return 128;
			7:       return 1024;
			8:       return 2047;
			9:       return $urandom_range(1023, 200);
			default: return $urandom_range(64, 5);
		endcase
	endfunction

	// Writes all six registers on consecutive cycles. Called only when nothing
	// is in flight, so the shadow registers can be updated right away.
	task automatic program_view(input int unsigned w, input int unsigned h,
			input int unsigned p, input rot_t r, input logic [1:0] m, input depth_t d);
		logic [CFG_W-1:0] vals [6];
		cfg_reg_t         idx;
		vals = '{CFG_W'(w), CFG_W'(h), CFG_W'(p), CFG_W'(r), CFG_W'(m), CFG_W'(d)};
		idx  = CFG_MEM_WIDTH;
		for (int i = 0; i < 6; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[i];
			idx = idx.next();
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		view_width  = DIM_W'(w);
		view_height = DIM_W'(h);
		view_pitch  = PITCH_W'(p);
		view_rot    = r;
		view_mirror = m;
		view_depth  = d;
		n_settings++;
		@(negedge clk);
	endtask

	// Sampled at the falling edge, where every driven value has settled.
	task automatic wait_drained();
		while (request_backlog.size() != 0 || in_valid || awaited_replies.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Request driver. On an input transfer the expected reply is computed at
	// once, so the shadow state follows the block's own acceptance order. A new
	// request goes onto the bus only when the old one has moved or none was
	// shown; a stalled request is never touched.
	always @(posedge clk) begin : request_driver
		fb_req_t on_bus;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				awaited_replies.push_back(paint_or_fetch(on_bus));
			end
			if (!in_valid || !in_stall) begin
				if (request_backlog.size() != 0 &&
						(calm || $urandom_range(99) >= IDLE_PCT)) begin
					on_bus = request_backlog.pop_front();
					in_valid    <= 1'b1;
					req_type    <= on_bus.req_type;
					pos_x       <= on_bus.pos_x;
					pos_y       <= on_bus.pos_y;
					pixel_color <= on_bus.pixel_color;
					read_addr   <= on_bus.read_addr;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Reply monitor. Each output transfer is matched against the oldest
	// expected reply. out_stall is read here before its new value lands, so
	// it reflects the cycle that is ending.
	always @(posedge clk) begin : reply_monitor
		fb_reply_t want;
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		if (arst_n && out_valid && !out_stall) begin
			n_replies++;
			if (awaited_replies.size() == 0) begin
				$error("reply transfer with nothing outstanding: status %0d read_byte 0x%02h",
					status, read_byte);
				fail_count++;
			end else begin
				want = awaited_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (read_byte !== want.read_byte) begin
					$error("read_byte: expected 0x%02h, got 0x%02h", want.read_byte, read_byte);
					fail_count++;
				end
			end
		end
	end

	// Hang detection: any transfer on either channel resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_count = 0;
		end else begin
			quiet_count++;
		end
		if (quiet_count >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d replies outstanding",
				quiet_count, awaited_replies.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned w, h, p, bpp, vw, vh, xlim, ylim, roll, color;
		depth_t      d;
		foreach (shadow_fb[i]) begin
			shadow_fb[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset configuration, left untouched: 128 by 128 at four bits per pixel.
		// These requests wait behind the clearing sweep. Corners of the view,
		// writes just past each side, and reads at both ends of the address range.
		push_write(0, 0, 16'hFFFF);
		push_write(127, 127, 16'h0005);
		push_write(128, 0, 16'h000F);
		push_write(0, 128, 16'h0001);
		push_write(1023, 1023, 16'hFFFF);
		push_read(0);
		push_read(8191);
		push_read(32767);
		wait_drained();

		// Largest view at one bit per pixel, rotated 90 degrees and mirrored on
		// both axes. The origin overruns the buffer; the others set and then
		// clear single bits, including one inside a byte written earlier.
		program_view(1024, 1024, 128, ROT_90, 2'b11, DEPTH_1BPP);
		push_write(0, 0, 16'h0001);
		push_write(1023, 1023, 16'hFFFF);
		push_read(127);
		push_write(1023, 1023, 16'h0000);
		push_read(127);
		push_write(1023, 0, 16'h0000);
		push_read(0);
		wait_drained();

		// Zero width: every write is dropped, whatever the position.
		program_view(0, 5, 10, ROT_180, 2'b01, DEPTH_2BPP);
		push_write(0, 0, 16'h0003);
		push_read(1);
		wait_drained();

		// Zero pitch at 16 bits per pixel: all rows fold onto row zero.
		program_view(16, 16, 0, ROT_270, 2'b10, DEPTH_16BPP);
		push_write(3, 5, 16'hA55A);
		push_write(3, 9, 16'h1234);
		push_read(10);
		push_read(11);
		push_read(18);
		wait_drained();

		// Last byte of the buffer at 16 bits per pixel: the pixel whose second
		// byte would fall past the end is dropped, the one before it fits.
		program_view(64, 1024, 33, ROT_0, 2'b00, DEPTH_16BPP);
		push_write(32, 991, 16'hBEEF);
		push_write(31, 991, 16'hCAFE);
		push_read(32765);
		push_read(32766);
		push_read(32767);
		wait_drained();

		// Random phases, each under a setting of its own. Most writes fall inside
		// the logical view and most reads go to bytes that were recently painted,
		// so merges into live data are read back; the rest are noise.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			d = depth_t'($urandom_range(3));
			case (ph)
				0: begin
					w = 1024;
					h = 1024;
					p = 4095;
				end
				1: begin
					w = 1;
					h = 1;
					p = 1;
				end
				default: begin
					w   = random_dim();
					h   = random_dim();
					bpp = (d == DEPTH_16BPP) ? 16 : (1 << d);
					p   = ($urandom_range(3) == 0) ? $urandom_range(4095) : (w * bpp + 7) / 8;
				end
			endcase
			program_view(w, h, p, rot_t'($urandom_range(3)), 2'($urandom_range(3)), d);
			calm = (ph == 3);
			vw   = (view_rot == ROT_90 || view_rot == ROT_270) ? view_height : view_width;
			vh   = (view_rot == ROT_90 || view_rot == ROT_270) ? view_width : view_height;
			xlim = (vw > 1024) ? 1023 : vw - 1;
			ylim = (vh > 1024) ? 1023 : vh - 1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				while (request_backlog.size() > 3) begin
					@(negedge clk);
				end
				roll  = $urandom_range(99);
				color = ($urandom_range(3) == 0) ? 0 : $urandom;
				if (roll < 55) begin
					push_write($urandom_range(xlim), $urandom_range(ylim), color);
				end else if (roll < 65) begin
					push_write($urandom, $urandom, color);
				end else if (roll < 90 && painted_addrs.size() != 0) begin
					push_read(painted_addrs[$urandom_range(painted_addrs.size() - 1)]);
				end else begin
					push_read($urandom);
				end
			end
			wait_drained();
			calm = 1'b0;
		end

		// Let any stray reply show up before the verdict.
		repeat (8) @(negedge clk);
		$display("Ran %0d requests (%0d pixel writes, %0d dropped; %0d byte reads)",
			n_writes + n_reads, n_writes, n_dropped, n_reads);
		$display("under %0d register settings besides reset; %0d replies checked",
			n_settings, n_replies);
		if (fail_count == 0 && awaited_replies.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire
